FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/gpx_pkg.sv
`timescale 1ns / 1ps

package gpx_pkg;

   localparam int COUNT_W = 30;
   localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

   localparam int CELL_W   = 4;
   localparam int TARGET_W = 4;
   localparam int GCOL_W   = 10;
   localparam int GROW_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_XOR   = 2'd0,
      CSR_GRID_COLUMNS = 2'd1,
      CSR_GRID_ROWS    = 2'd2
   } csr_index_type;

   // Per-cell control worked out when the beat is taken.
   typedef struct packed {
      logic first;     // top-left cell: seed one path
      logic has_up;    // a row above exists
      logic has_left;  // a cell to the left exists
      logic bypass;    // row entry is being written by the cell just before
      logic last;      // last cell of the grid
   } cell_ctrl_type;

endpackage

FILE: rtl/grid_path_xor_counter_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Counts right/down grid paths whose cell values XOR to csr target_xor.
// Cells stream in row-major order on req_* (one 4-bit cell per beat); after
// the last cell of a grid one beat on rsp_* carries the count modulo
// 1000000007, and the next cell starts a new grid.
// csr_* writes target_xor (index 0), grid_columns (1) and grid_rows (2);
// write them only with no cell in flight. csr_ready is always high.
// Throughput: one cell per cycle. Each cell reads its column's 16 counts
// from the row store in the cycle it is taken, then all 16 lanes do their
// modular add in the next cycle against the prefetched row word.
// rsp_valid rises once the last cell leaves the work stage.
// Reset clears the row/column position and restores the register defaults;
// the row store is not cleared (no clearing pass, ready right out of reset).
// When the receiver stalls a pending result, the following last cell holds
// in the work stage and req_ready drops; other cells keep flowing.
module grid_path_xor_counter_top #(
   parameter int MAX_COLUMNS = 512,
   parameter int XOR_BITS    = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gpx_pkg::CELL_W-1:0]         req_cell_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gpx_pkg::COUNT_W-1:0]        rsp_path_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gpx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpx_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NV = 1 << XOR_BITS;
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [15:0] MAX_COLS16 = 16'(MAX_COLUMNS);
   localparam logic [15:0] MAX_COL_IDX16 = 16'(MAX_COLUMNS - 1);

   typedef logic [NV-1:0][gpx_pkg::COUNT_W-1:0] count_vec_type;

   // Configuration
   logic [gpx_pkg::TARGET_W-1:0] target_xor_ff;
   logic [gpx_pkg::GCOL_W-1:0]   grid_columns_ff;
   logic [gpx_pkg::GROW_W-1:0]   grid_rows_ff;

   // Position
   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;

   // Work stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [XOR_BITS-1:0]    s1_cell_ff;
   logic [CW-1:0]          s1_col_ff;
   gpx_pkg::cell_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   count_vec_type          left_ff;

   // Result
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gpx_pkg::COUNT_W-1:0] rsp_count_ff;

   logic          req_fire, s1_adv;
   logic [15:0]   col_eff16, cols_eff16, rows_eff16;
   logic [CW-1:0] col_eff;
   logic          col_last, row_last;
   logic [XOR_BITS-1:0] cell_in;
   logic [XOR_BITS-1:0] target_sel;
   logic [7:0]    cell8, target8;
   count_vec_type row_word, fresh;
   logic [NV*gpx_pkg::COUNT_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_xor_ff   <= '0;
         grid_columns_ff <= gpx_pkg::GCOL_W'(1);
         grid_rows_ff    <= gpx_pkg::GROW_W'(1);
      end else if (csr_valid) begin
         unique case (gpx_pkg::csr_index_type'(csr_index))
            gpx_pkg::CSR_TARGET_XOR:   target_xor_ff   <= csr_wdata[gpx_pkg::TARGET_W-1:0];
            gpx_pkg::CSR_GRID_COLUMNS: grid_columns_ff <= csr_wdata[gpx_pkg::GCOL_W-1:0];
            gpx_pkg::CSR_GRID_ROWS:    grid_rows_ff    <= csr_wdata[gpx_pkg::GROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshakes
   assign s1_adv    = s1_valid_ff && (!s1_ctrl_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // Cell value and target cut to the XOR width
   assign cell8      = 8'(req_cell_value);
   assign cell_in    = cell8[XOR_BITS-1:0];
   assign target8    = 8'(target_xor_ff);
   assign target_sel = target8[XOR_BITS-1:0];

   always_comb begin
      col_eff16 = 16'(col_ff);
      if (col_eff16 > MAX_COL_IDX16) begin
         col_eff16 = MAX_COL_IDX16;
      end
      col_eff = col_eff16[CW-1:0];

      cols_eff16 = 16'(grid_columns_ff);
      if (cols_eff16 == 16'd0) begin
         cols_eff16 = 16'd1;
      end else if (cols_eff16 > MAX_COLS16) begin
         cols_eff16 = MAX_COLS16;
      end

      rows_eff16 = (grid_rows_ff == '0) ? 16'd1 : grid_rows_ff;

      col_last = (17'(col_eff16) + 17'd1) >= 17'(cols_eff16);
      row_last = (17'(row_ff) + 17'd1) >= 17'(rows_eff16);

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 16'd1;
         end else begin
            col_in = CW'(col_eff16 + 16'd1);
         end
      end

      s1_ctrl_in.first    = (row_ff == '0) && (col_eff == '0);
      s1_ctrl_in.has_up   = (row_ff != '0);
      s1_ctrl_in.has_left = (col_eff != '0);
      s1_ctrl_in.bypass   = s1_adv && (s1_col_ff == col_eff);
      s1_ctrl_in.last     = col_last && row_last;

      s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

      if (s1_adv && s1_ctrl_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cell_ff <= cell_in;
         s1_col_ff  <= col_eff;
         s1_ctrl_ff <= s1_ctrl_in;
      end
      if (s1_adv) begin
         left_ff <= fresh;
      end
      if (s1_adv && s1_ctrl_ff.last) begin
         rsp_count_ff <= fresh[target_sel];
      end
   end

   // Row store: one word of all XOR counts per column, prefetched on accept
   gpx_ram #(
      .WIDTH (NV * gpx_pkg::COUNT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (fresh),
      .rd_en   (req_fire),
      .rd_addr (col_eff),
      .rd_data (ram_rd_data)
   );

   assign row_word = ram_rd_data;

   gpx_cell_update #(
      .XOR_BITS (XOR_BITS)
   ) u_cell_update (
      .cell_value (s1_cell_ff),
      .ctrl       (s1_ctrl_ff),
      .row_word   (row_word),
      .left_word  (left_ff),
      .fresh      (fresh)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;

   // A last cell only waits while an older result is stuck at the output.
   `ASSERT_IMPLIES(a_last_held, clock, reset, s1_valid_ff && s1_ctrl_ff.last && !s1_adv, rsp_valid_ff && !rsp_ready)
   // Same-column forwarding only happens in a one-column grid.
   `ASSERT_IMPLIES(a_bypass_col0, clock, reset, s1_valid_ff && s1_ctrl_ff.bypass, !s1_ctrl_ff.has_left)
   // A taken result with no new one behind it drops valid.
   `ASSERT_NEXT(a_rsp_drain, clock, reset, rsp_valid_ff && rsp_ready && !(s1_adv && s1_ctrl_ff.last), !rsp_valid_ff)

endmodule

FILE: rtl/gpx_ram.sv
`timescale 1ns / 1ps

module gpx_ram #(
   parameter int WIDTH = 480,
   parameter int DEPTH = 512
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gpx_cell_update.sv
`timescale 1ns / 1ps

module gpx_cell_update #(
   parameter int XOR_BITS = 4
) (
   input  logic [XOR_BITS-1:0]                                cell_value,
   input  gpx_pkg::cell_ctrl_type                             ctrl,
   input  logic [(1 << XOR_BITS)-1:0][gpx_pkg::COUNT_W-1:0]   row_word,
   input  logic [(1 << XOR_BITS)-1:0][gpx_pkg::COUNT_W-1:0]   left_word,
   output logic [(1 << XOR_BITS)-1:0][gpx_pkg::COUNT_W-1:0]   fresh
);

   localparam int NV = 1 << XOR_BITS;

   logic [XOR_BITS:0][NV-1:0][gpx_pkg::COUNT_W-1:0] up_perm;
   logic [XOR_BITS:0][NV-1:0][gpx_pkg::COUNT_W-1:0] left_perm;

   // Row entry is still in flight when the same column repeats: the left
   // counts hold exactly that cell's result.
   assign up_perm[0]   = ctrl.bypass ? left_word : row_word;
   assign left_perm[0] = left_word;

   // XOR butterfly: lane x picks source x ^ cell_value, one bit per stage.
   for (genvar k = 0; k < XOR_BITS; k++) begin : g_stage
      for (genvar x = 0; x < NV; x++) begin : g_swap
         assign up_perm[k+1][x]   = cell_value[k] ? up_perm[k][x ^ (1 << k)] : up_perm[k][x];
         assign left_perm[k+1][x] = cell_value[k] ? left_perm[k][x ^ (1 << k)]
                                                  : left_perm[k][x];
      end
   end

   for (genvar x = 0; x < NV; x++) begin : g_lane
      logic [gpx_pkg::COUNT_W-1:0] up_term;
      logic [gpx_pkg::COUNT_W-1:0] left_term;
      logic [gpx_pkg::COUNT_W:0]   sum;

      always_comb begin
         up_term   = ctrl.has_up   ? up_perm[XOR_BITS][x]   : '0;
         left_term = ctrl.has_left ? left_perm[XOR_BITS][x] : '0;
         sum       = {1'b0, up_term} + {1'b0, left_term};
         if (ctrl.first) begin
            fresh[x] = (cell_value == XOR_BITS'(x)) ? gpx_pkg::COUNT_W'(1) : '0;
         end else if (sum >= {1'b0, gpx_pkg::COUNT_MOD}) begin
            fresh[x] = gpx_pkg::COUNT_W'(sum - {1'b0, gpx_pkg::COUNT_MOD});
         end else begin
            fresh[x] = sum[gpx_pkg::COUNT_W-1:0];
         end
      end
   end

endmodule
